// ----- hw/rtl/cbg_pkg.sv -----
package cbg_pkg;

    localparam int TIME_BITS   = 48;
    localparam int THR_BITS    = 14;
    localparam int COOL_BITS   = 22;
    localparam int STATUS_BITS = 10;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;

    localparam logic [THR_BITS-1:0]    COUNT_MAX       = 14'd16383;
    localparam logic [STATUS_BITS-1:0] STATUS_NEUTRAL  = 10'd429;
    localparam logic [STATUS_BITS-1:0] STATUS_FAIL_MIN = 10'd500;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        REG_FAIL_THRESHOLD = 1'b0,
        REG_COOLDOWN_MS    = 1'b1
    } cbg_reg_t;

    typedef enum logic [1:0] {
        CLS_QUERY,
        CLS_FAIL,
        CLS_SUCCESS,
        CLS_NEUTRAL
    } cbg_cls_t;

    typedef struct packed {
        cbg_cls_t             cls;
        logic [TIME_BITS-1:0] now_ms;
    } cbg_entry_t;

    typedef struct packed {
        logic [THR_BITS-1:0]  fail_threshold;
        logic [COOL_BITS-1:0] cooldown_ms;
    } cbg_cfg_t;

    typedef struct packed {
        logic       valid;
        cbg_entry_t entry;
    } cbg_head_t;

endpackage

// ----- hw/rtl/circuit_breaker_gate_core.sv -----
// Circuit breaker gate with a single half-open probe.
// Input channel (s_*): one request per item, either a gate query (s_action = 0)
// or a reported outcome (s_action = 1) carrying transport status and HTTP code.
// Output channel (m_*): exactly one result per request, in order: allowed,
// is_open, tripped, recovered and the saturating failure count.
// An accepted request is queued and then popped into the output register.
// Throughput: one request per cycle while m_ready holds; the front classifies
// into a 2-entry queue; the back updates breaker state and the output together.
// Receiver stall: the output register holds its result; the queue absorbs up to
// two further requests, after which s_ready drops until the receiver resumes.
// Reset (aresetn low, synchronous): failure count, open window and probe flag
// clear, queue and output empty; fail_threshold returns to 10, cooldown_ms to
// 10000. Config via APB: fail_threshold at 0x0, cooldown_ms at 0x4; the user must
// write them only while the block is idle, which the block does not enforce.
module circuit_breaker_gate_core
    import cbg_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_action,
    input  logic [TIME_BITS-1:0]   s_now_ms,
    input  logic                   s_transport_ok,
    input  logic [STATUS_BITS-1:0] s_http_status,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_allowed,
    output logic                   m_is_open,
    output logic                   m_tripped,
    output logic                   m_recovered,
    output logic [THR_BITS-1:0]    m_failure_count
);

    cbg_cfg_t   cfg_reg;
    cbg_reg_t   reg_sel;
    logic       cfg_wr;
    cbg_entry_t front_entry;
    cbg_head_t  head;
    logic       q_full;
    logic       pop;
    logic       push;

    assign pready  = 1'b1;
    assign reg_sel = cbg_reg_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fail_threshold <= THR_BITS'(10);
            cfg_reg.cooldown_ms    <= COOL_BITS'(10000);
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_FAIL_THRESHOLD: cfg_reg.fail_threshold <= pwdata[THR_BITS-1:0];
                REG_COOLDOWN_MS:    cfg_reg.cooldown_ms    <= pwdata[COOL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_FAIL_THRESHOLD: prdata = CFG_DATA_W'(cfg_reg.fail_threshold);
            REG_COOLDOWN_MS:    prdata = CFG_DATA_W'(cfg_reg.cooldown_ms);
            default:            prdata = '0;
        endcase
    end

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    cbg_front u_front (
        .action       (s_action),
        .now_ms       (s_now_ms),
        .transport_ok (s_transport_ok),
        .http_status  (s_http_status),
        .entry        (front_entry)
    );

    cbg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head)
    );

    cbg_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .head            (head),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_allowed       (m_allowed),
        .m_is_open       (m_is_open),
        .m_tripped       (m_tripped),
        .m_recovered     (m_recovered),
        .m_failure_count (m_failure_count)
    );

endmodule

// ----- hw/rtl/cbg_front.sv -----
module cbg_front
    import cbg_pkg::*;
(
    input  logic                   action,
    input  logic [TIME_BITS-1:0]   now_ms,
    input  logic                   transport_ok,
    input  logic [STATUS_BITS-1:0] http_status,
    output cbg_entry_t             entry
);

    logic fail;

    // transport error or 5xx and above is a failure; 429 is neutral
    assign fail = !transport_ok || (http_status >= STATUS_FAIL_MIN);

    always_comb begin
        entry.now_ms = now_ms;
        if (!action) begin
            entry.cls = CLS_QUERY;
        end else if (fail) begin
            entry.cls = CLS_FAIL;
        end else if (http_status == STATUS_NEUTRAL) begin
            entry.cls = CLS_NEUTRAL;
        end else begin
            entry.cls = CLS_SUCCESS;
        end
    end

endmodule

// ----- hw/rtl/cbg_queue.sv -----
module cbg_queue
    import cbg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  cbg_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output cbg_head_t  head
);

    cbg_entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]       count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + QPTR_W'(1);
    endfunction

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- hw/rtl/cbg_back.sv -----
module cbg_back
    import cbg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cbg_cfg_t            cfg,
    input  cbg_head_t           head,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_allowed,
    output logic                m_is_open,
    output logic                m_tripped,
    output logic                m_recovered,
    output logic [THR_BITS-1:0] m_failure_count
);

    logic [THR_BITS-1:0]  fail_count_reg, fail_count_next;
    logic [TIME_BITS-1:0] open_until_reg, open_until_next;
    logic                 probe_busy_reg, probe_busy_next;
    logic                 m_valid_reg;
    logic                 allowed_reg, is_open_reg, tripped_reg, recovered_reg;
    logic [THR_BITS-1:0]  count_out_reg;

    logic                 enabled;
    logic [THR_BITS-1:0]  cnt_inc;
    logic [TIME_BITS:0]   win_sum;
    logic [TIME_BITS-1:0] win_end;
    logic                 allowed_next, tripped_next, recovered_next;

    assign enabled = (cfg.fail_threshold != '0);
    assign pop     = head.valid && (!m_valid_reg || m_ready);
    assign cnt_inc = (fail_count_reg != COUNT_MAX) ? fail_count_reg + THR_BITS'(1)
                                                   : fail_count_reg;
    assign win_sum = {1'b0, head.entry.now_ms} + (TIME_BITS + 1)'(cfg.cooldown_ms);
    assign win_end = win_sum[TIME_BITS] ? '1 : win_sum[TIME_BITS-1:0];

    always_comb begin
        fail_count_next = fail_count_reg;
        open_until_next = open_until_reg;
        probe_busy_next = probe_busy_reg;
        allowed_next    = 1'b0;
        tripped_next    = 1'b0;
        recovered_next  = 1'b0;
        case (head.entry.cls)
            CLS_QUERY: begin
                if (!enabled || fail_count_reg < cfg.fail_threshold) begin
                    allowed_next = 1'b1;
                end else if (head.entry.now_ms >= open_until_reg && !probe_busy_reg) begin
                    probe_busy_next = 1'b1;
                    allowed_next    = 1'b1;
                end
            end
            CLS_FAIL: begin
                if (enabled) begin
                    probe_busy_next = 1'b0;
                    fail_count_next = cnt_inc;
                    if (cnt_inc >= cfg.fail_threshold) begin
                        open_until_next = win_end;
                        tripped_next    = (cnt_inc == cfg.fail_threshold) &&
                                          (fail_count_reg != COUNT_MAX);
                    end
                end
            end
            CLS_SUCCESS: begin
                if (enabled) begin
                    probe_busy_next = 1'b0;
                    recovered_next  = (fail_count_reg >= cfg.fail_threshold);
                    fail_count_next = '0;
                end
            end
            CLS_NEUTRAL: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fail_count_reg <= '0;
            open_until_reg <= '0;
            probe_busy_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (pop) begin
                fail_count_reg <= fail_count_next;
                open_until_reg <= open_until_next;
                probe_busy_reg <= probe_busy_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            allowed_reg   <= allowed_next;
            is_open_reg   <= enabled && (fail_count_next >= cfg.fail_threshold);
            tripped_reg   <= tripped_next;
            recovered_reg <= recovered_next;
            count_out_reg <= fail_count_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_allowed       = allowed_reg;
    assign m_is_open       = is_open_reg;
    assign m_tripped       = tripped_reg;
    assign m_recovered     = recovered_reg;
    assign m_failure_count = count_out_reg;

endmodule

// ----- hw/rtl/cbg_checker.sv -----
module cbg_checker
    import cbg_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_is_open,
    input logic                m_tripped,
    input logic                m_recovered,
    input logic [THR_BITS-1:0] m_failure_count
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_trip_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tripped |-> m_is_open && !m_recovered)
        else $error("trip without open breaker");

    a_recover_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_recovered |-> m_failure_count == '0 && !m_is_open)
        else $error("recovery left failures counted");

    a_open_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_open |-> m_failure_count != '0)
        else $error("open breaker with zero failures");

endmodule

bind circuit_breaker_gate_core cbg_checker u_cbg_checker (.*);

// ----- verif/tb_circuit_breaker_gate_core.sv -----
module tb_circuit_breaker_gate_core;
    import cbg_pkg::*;

    localparam logic ACT_QUERY  = 1'b0;
    localparam logic ACT_REPORT = 1'b1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_CAP      = 100;

    typedef struct packed {
        logic                allowed;
        logic                is_open;
        logic                tripped;
        logic                recovered;
        logic [THR_BITS-1:0] count;
    } gate_result_t;

    class breaker_scoreboard;
        logic [THR_BITS-1:0]  threshold;
        logic [COOL_BITS-1:0] cooldown;
        logic [THR_BITS-1:0]  fail_count;
        logic [TIME_BITS-1:0] open_until;
        bit                   probe_busy;
        gate_result_t         expected_q[$];
        int                   errors;
        int                   results;

        function new();
            threshold  = 14'd10;
            cooldown   = 22'd10000;
            fail_count = '0;
            open_until = '0;
            probe_busy = 1'b0;
            errors     = 0;
            results    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_reg(cbg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_FAIL_THRESHOLD) begin
                threshold = val[THR_BITS-1:0];
            end else begin
                cooldown = val[COOL_BITS-1:0];
            end
        endfunction

        task report(string msg);
            if (errors < PRINT_CAP) begin
                $display("mismatch: %s", msg);
            end
            errors++;
        endtask

        // breaker state update for one accepted request
        function void note_request(logic act, logic [TIME_BITS-1:0] now, logic xok,
                                   logic [STATUS_BITS-1:0] st);
            gate_result_t        r;
            logic                enabled;
            logic                failed;
            logic                neutral;
            logic [THR_BITS-1:0] prev;
            logic [TIME_BITS:0]  sum;
            r = '0;
            enabled = (threshold != '0);
            if (act == ACT_QUERY) begin
                if (!enabled || fail_count < threshold) begin
                    r.allowed = 1'b1;
                end else if (now < open_until) begin
                    r.allowed = 1'b0;
                end else if (probe_busy) begin
                    r.allowed = 1'b0;
                end else begin
                    probe_busy = 1'b1;
                    r.allowed  = 1'b1;
                end
            end else if (enabled) begin
                failed  = !xok || (st >= STATUS_FAIL_MIN);
                neutral = !failed && (st == STATUS_NEUTRAL);
                if (failed) begin
                    prev = fail_count;
                    probe_busy = 1'b0;
                    if (fail_count < COUNT_MAX) begin
                        fail_count = fail_count + 1'b1;
                    end
                    if (fail_count >= threshold) begin
                        sum = {1'b0, now} + (TIME_BITS + 1)'(cooldown);
                        open_until = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
                        r.tripped = (fail_count == threshold) && (fail_count != prev);
                    end
                end else if (!neutral) begin
                    probe_busy  = 1'b0;
                    r.recovered = (fail_count >= threshold);
                    fail_count  = '0;
                end
            end
            r.is_open = enabled && (fail_count >= threshold);
            r.count   = fail_count;
            expected_q.insert(expected_q.size(), r);
        endfunction

        task check_result(gate_result_t got);
            gate_result_t exp;
            results++;
            if (expected_q.size() == 0) begin
                report($sformatf("result %0d with no request pending", results));
                return;
            end
            exp = expected_q[0];
            expected_q.delete(0);
            if (got.allowed !== exp.allowed)
                report($sformatf("result %0d allowed %0b exp %0b",
                                 results, got.allowed, exp.allowed));
            if (got.is_open !== exp.is_open)
                report($sformatf("result %0d is_open %0b exp %0b",
                                 results, got.is_open, exp.is_open));
            if (got.tripped !== exp.tripped)
                report($sformatf("result %0d tripped %0b exp %0b",
                                 results, got.tripped, exp.tripped));
            if (got.recovered !== exp.recovered)
                report($sformatf("result %0d recovered %0b exp %0b",
                                 results, got.recovered, exp.recovered));
            if (got.count !== exp.count)
                report($sformatf("result %0d failure_count %0d exp %0d",
                                 results, got.count, exp.count));
        endtask
    endclass

    logic                   aclk;
    logic                   aresetn        = 1'b0;
    logic                   psel           = 1'b0;
    logic                   penable        = 1'b0;
    logic                   pwrite         = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr          = '0;
    logic [CFG_DATA_W-1:0]  pwdata         = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic                   s_action       = 1'b0;
    logic [TIME_BITS-1:0]   s_now_ms       = '0;
    logic                   s_transport_ok = 1'b0;
    logic [STATUS_BITS-1:0] s_http_status  = '0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic                   m_allowed;
    logic                   m_is_open;
    logic                   m_tripped;
    logic                   m_recovered;
    logic [THR_BITS-1:0]    m_failure_count;

    breaker_scoreboard    sb;
    bit                   quiet = 1'b0;
    int                   cur_cool = 10000;
    logic [TIME_BITS-1:0] wall_ms = '0;
    int                   stall_cycles = 0;

    circuit_breaker_gate_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_now_ms       (s_now_ms),
        .s_transport_ok (s_transport_ok),
        .s_http_status  (s_http_status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_allowed      (m_allowed),
        .m_is_open      (m_is_open),
        .m_tripped      (m_tripped),
        .m_recovered    (m_recovered),
        .m_failure_count(m_failure_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver back-pressure in bursts
    initial begin
        int n;
        bit stall;
        @(posedge aclk);
        forever begin
            n = $urandom_range(1, 13);
            stall = !quiet && ($urandom_range(0, 2) == 0);
            m_ready <= !stall;
            repeat (n) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        gate_result_t got;
        if (aresetn && s_valid && s_ready) begin
            sb.note_request(s_action, s_now_ms, s_transport_ok, s_http_status);
        end
        if (aresetn && m_valid && m_ready) begin
            got = '{allowed: m_allowed, is_open: m_is_open, tripped: m_tripped,
                    recovered: m_recovered, count: m_failure_count};
            sb.check_result(got);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_request(input logic act, input logic [TIME_BITS-1:0] t,
                                input logic xok, input logic [STATUS_BITS-1:0] st);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_action       <= act;
        s_now_ms       <= t;
        s_transport_ok <= xok;
        s_http_status  <= st;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0) @(negedge aclk);
        @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input cbg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        int w;
        w = (idx == REG_FAIL_THRESHOLD) ? THR_BITS : COOL_BITS;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val | (CFG_DATA_W'($urandom) << w);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
        if (idx == REG_COOLDOWN_MS) cur_cool = val;
        @(posedge aclk);
    endtask

    task automatic random_request(input int fail_pct);
        logic                   act;
        logic                   xok;
        logic [STATUS_BITS-1:0] st;
        logic [TIME_BITS-1:0]   t;
        int                     sel;
        int                     inc;
        int                     roll;
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
            t = TIME_BITS'({$urandom, $urandom});
        end else begin
            if (sel < 30) inc = $urandom_range(cur_cool / 2, 2 * cur_cool + 2);
            else inc = $urandom_range(0, cur_cool / 8 + 1);
            wall_ms = (wall_ms > TIME_MAX - inc) ? TIME_MAX : wall_ms + inc;
            t = wall_ms;
        end
        act = 1'($urandom_range(0, 1));
        xok = 1'b1;
        st  = STATUS_BITS'($urandom_range(0, 1023));
        if (act == ACT_QUERY) begin
            xok = 1'($urandom_range(0, 1));
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < fail_pct) begin
                if ($urandom_range(0, 1)) xok = 1'b0;
                else st = STATUS_BITS'($urandom_range(STATUS_FAIL_MIN, 1023));
            end else if (roll < fail_pct + 8) begin
                st = STATUS_NEUTRAL;
            end else begin
                st = STATUS_BITS'($urandom_range(0, STATUS_FAIL_MIN - 1));
            end
        end
        send_request(act, t, xok, st);
    endtask

    initial begin
        int thr_tab[8]  = '{3, 1, 5, 0, 2, 10000, 7, 4};
        int cool_tab[8] = '{50, 1, 1000, 20, 3600000, 1, 300, 2};
        int fail_pct;
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: success, neutral, status boundaries, transport error
        send_request(ACT_QUERY,  48'd0, 1'b1, 10'd0);
        send_request(ACT_REPORT, 48'd1, 1'b1, 10'd200);
        send_request(ACT_REPORT, 48'd2, 1'b1, STATUS_NEUTRAL);
        send_request(ACT_REPORT, 48'd3, 1'b1, 10'd499);
        send_request(ACT_REPORT, 48'd4, 1'b1, STATUS_FAIL_MIN);
        send_request(ACT_REPORT, 48'd5, 1'b1, 10'd1023);
        send_request(ACT_REPORT, 48'd6, 1'b0, 10'd0);
        drain();

        // zero cooldown, neutral report, fail and success while closed, trip
        cfg_write(REG_FAIL_THRESHOLD, 32'd2);
        cfg_write(REG_COOLDOWN_MS, 32'd0);
        send_request(ACT_QUERY,  48'd100, 1'b1, 10'd0);
        send_request(ACT_QUERY,  48'd100, 1'b1, 10'd0);
        send_request(ACT_REPORT, 48'd100, 1'b1, STATUS_NEUTRAL);
        send_request(ACT_QUERY,  48'd101, 1'b1, 10'd0);
        send_request(ACT_REPORT, 48'd101, 1'b0, 10'd200);
        send_request(ACT_QUERY,  48'd101, 1'b1, 10'd0);
        send_request(ACT_REPORT, 48'd101, 1'b1, 10'd204);
        send_request(ACT_REPORT, 48'd102, 1'b1, 10'd503);
        send_request(ACT_REPORT, 48'd102, 1'b0, 10'd0);
        drain();

        // window saturates at the top of the time range
        cfg_write(REG_FAIL_THRESHOLD, 32'd1);
        cfg_write(REG_COOLDOWN_MS, 32'd3600000);
        send_request(ACT_REPORT, TIME_MAX - 5, 1'b1, 10'd500);
        send_request(ACT_QUERY,  TIME_MAX - 1, 1'b1, 10'd0);
        send_request(ACT_QUERY,  TIME_MAX,     1'b1, 10'd0);
        send_request(ACT_QUERY,  TIME_MAX,     1'b1, 10'd0);
        drain();

        // disabled breaker
        cfg_write(REG_FAIL_THRESHOLD, 32'd0);
        send_request(ACT_QUERY,  48'd7, 1'b1, 10'd0);
        send_request(ACT_REPORT, 48'd8, 1'b0, 10'd0);
        send_request(ACT_REPORT, 48'd9, 1'b1, 10'd200);
        drain();

        for (int p = 0; p < 8; p++) begin
            quiet = (p == 7);
            cfg_write(REG_FAIL_THRESHOLD, thr_tab[p]);
            cfg_write(REG_COOLDOWN_MS, cool_tab[p]);
            if (p == 4) wall_ms = TIME_MAX - $urandom_range(0, 50000000);
            else wall_ms = TIME_BITS'({$urandom_range(0, 32767), $urandom});
            fail_pct = 40;
            for (int n = 0; n < 94; n++) begin
                if (n % 12 == 0) begin
                    case ($urandom_range(0, 2))
                        0: fail_pct = 5;
                        1: fail_pct = 40;
                        default: fail_pct = 85;
                    endcase
                end
                random_request(fail_pct);
            end
            drain();
        end

        repeat (16) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
